// ===== hw/rtl/frti_pkg.sv =====
// Package: shared types, mode codes and the rounding function.
package frti_pkg;

  typedef enum logic [1:0] {
    FUNC_FLOOR = 2'd0,
    FUNC_CEIL  = 2'd1,
    FUNC_ROUND = 2'd2,
    FUNC_SPARE = 2'd3
  } func_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  func;
  } op_t;

  typedef struct packed {
    logic [31:0]        float_bits;
    logic signed [31:0] int_value;
    logic               overflow;
  } res_t;

  localparam logic [31:0] NEG_ONE  = 32'hBF800000;
  localparam logic [31:0] POS_ONE  = 32'h3F800000;
  localparam logic [31:0] NEG_ZERO = 32'h80000000;
  localparam logic [7:0]  BIAS     = 8'd127;

  // Truncate toward minus (down=1) or plus infinity.
  function automatic logic [31:0] dir_round(input logic [31:0] b, input logic down);
    logic [7:0]  be;
    logic [31:0] m;
    logic        away;
    logic [31:0] r;
    be   = b[30:23];
    m    = 32'h007FFFFF >> (be - BIAS);
    away = down ? b[31] : !b[31];
    if (be >= 8'd150) begin
      r = b;
    end else if (be >= BIAS) begin
      if ((b & m) == 32'd0) r = b;
      else r = (away ? b + m : b) & ~m;
    end else if (down) begin
      r = b[31] ? ((b[30:0] != 31'd0) ? NEG_ONE : b) : 32'd0;
    end else begin
      r = b[31] ? NEG_ZERO : ((b != 32'd0) ? POS_ONE : 32'd0);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/float_round_to_integral.sv =====
// Top level: input register, rounding datapath, result register.
// An item passes the input reg, then the result reg; a stall can hold it in between.
// Throughput: one item per cycle unless stalled; datapath is a single registered pass.
// Each stage advances when empty or when the stage after it moves on.
// Reset (rst, synchronous) clears both valid flags; no other state.
module float_round_to_integral (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          value,
  input  logic [1:0]           func,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          float_bits,
  output logic signed [31:0]   int_value,
  output logic                 overflow
);
  import frti_pkg::*;

  op_t  op;
  logic op_valid;
  res_t res;
  res_t res_q;
  logic adv_out;

  assign adv_out  = !out_valid || out_ready;
  assign in_ready = !op_valid || adv_out;

  frti_core u_core (.op(op), .res(res));

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) op_valid <= in_valid;
      if (adv_out) out_valid <= op_valid;
    end
    if (in_ready && in_valid) op <= '{value: value, func: func};
    if (adv_out && op_valid) res_q <= res;
  end

  assign float_bits = res_q.float_bits;
  assign int_value  = res_q.int_value;
  assign overflow   = res_q.overflow;

endmodule

// ===== hw/rtl/frti_half_add.sv =====
// Exact binary32 sum of the operand and one half, round to nearest even.
module frti_half_add (
  input  logic [31:0] b,
  output logic [31:0] sum
);
  import frti_pkg::*;

  logic [7:0]  be;
  logic [23:0] mant;
  logic [7:0]  eb;
  logic [55:0] a;
  logic        st;
  logic        neg;
  logic [55:0] t;
  logic [5:0]  p;
  logic [55:0] sh;
  logic [23:0] m;
  logic        rb;
  logic        sticky2;
  logic [8:0]  e;
  logic [31:0] mag;

  // Operand lies below 2^24, so fixed point with 32 fraction bits fits 56 bits.
  always_comb begin
    be   = b[30:23];
    mant = {(be != 8'd0), b[22:0]};
    eb   = (be != 8'd0) ? be : 8'd1;
    a    = 56'd0;
    st   = 1'b0;
    if (eb >= 8'd118) begin
      a = {32'd0, mant} << (eb - 8'd118);
    end else if ((8'd118 - eb) >= 8'd24) begin
      st = (mant != 24'd0);
    end else begin
      a  = {32'd0, mant >> (8'd118 - eb)};
      st = ((mant << (8'd24 - (8'd118 - eb))) & 24'hFFFFFF) != 24'd0;
    end
    neg = 1'b0;
    if (!b[31]) begin
      t = a + 56'h80000000;
    end else if (st) begin
      t = 56'h80000000 - a - 56'd1;
    end else if (a > 56'h80000000) begin
      t = a - 56'h80000000;
      neg = 1'b1;
    end else begin
      t = 56'h80000000 - a;
    end
    p = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (t[i]) p = 6'(i);
    end
    // Left-align leading one at bit 55; take 24 bits, round bit, sticky.
    sh      = t << (6'd55 - p);
    m       = sh[55:32];
    rb      = sh[31];
    sticky2 = (sh[30:0] != 31'd0) || st;
    e       = {3'd0, p} + 9'd94;
    // The leading one of m carries into the exponent field.
    mag     = {e[7:0], 23'd0} + {8'd0, m};
    if (rb && (sticky2 || m[0])) mag = mag + 32'd1;
    if (t == 56'd0 && !st) sum = 32'd0;
    else sum = {neg, 31'd0} | mag;
  end

endmodule

// ===== hw/rtl/frti_core.sv =====
// Combinational rounding datapath and integer conversion.
module frti_core (
  input  frti_pkg::op_t  op,
  output frti_pkg::res_t res
);
  import frti_pkg::*;

  logic [31:0] sum;
  logic [31:0] rnd;
  logic [31:0] r;
  logic [7:0]  be;
  logic [31:0] mv;
  logic [31:0] mag;

  frti_half_add u_half (.b(op.value), .sum(sum));

  always_comb begin
    if (op.value[30:23] == 8'hFF)
      rnd = (op.value[22:0] != 23'd0) ? (op.value | 32'h00400000) : op.value;
    else if (op.value[30:23] >= 8'd151)
      rnd = op.value;
    else
      rnd = dir_round(sum, 1'b1);
    case (op.func)
      FUNC_CEIL:  r = dir_round(op.value, 1'b0);
      FUNC_ROUND: r = rnd;
      default:    r = dir_round(op.value, 1'b1);
    endcase
    be  = r[30:23];
    mv  = {8'd0, 1'b1, r[22:0]};
    mag = (be <= 8'd150) ? (mv >> (8'd150 - be)) : (mv << (be - 8'd150));
    res.float_bits = r;
    res.overflow   = (be >= 8'd158);
    if (be >= 8'd158 || be < BIAS) res.int_value = 32'sd0;
    else res.int_value = r[31] ? $signed(32'd0 - mag) : $signed(mag);
  end

endmodule
